// File: sv/array_priority_queue_macros.svh
// Assertion macros for the priority queue RTL.
`ifndef ARRAY_PRIORITY_QUEUE_MACROS_SVH
`define ARRAY_PRIORITY_QUEUE_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define APQ_ASSERT_NOW(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("priority queue check failed");

// Next-cycle implication, sampled on clk, off during reset.
`define APQ_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("priority queue check failed");

`endif

// File: sv/apq_pkg.sv
// Types, sizes and command codes for the array priority queue.
package apq_pkg;

  localparam int DEPTH          = 16;
  localparam int VALUE_WIDTH    = 32;
  localparam int PRIORITY_WIDTH = 32;
  localparam int IDX_W          = $clog2(DEPTH);
  localparam int CNT_W          = $clog2(DEPTH + 1);
  localparam int ENTRY_W        = VALUE_WIDTH + PRIORITY_WIDTH;

  localparam logic [1:0] CMD_ENQ   = 2'd0;
  localparam logic [1:0] CMD_DEQ   = 2'd1;
  localparam logic [1:0] CMD_PEEK  = 2'd2;
  localparam logic [1:0] CMD_CLEAR = 2'd3;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  typedef struct packed {
    logic [1:0]                       cmd;
    logic signed [VALUE_WIDTH-1:0]    value_in;
    logic signed [PRIORITY_WIDTH-1:0] priority_in;
  } apq_in_t;

  typedef struct packed {
    logic signed [VALUE_WIDTH-1:0]    top_value;
    logic signed [PRIORITY_WIDTH-1:0] top_priority;
    logic                             top_valid;
    logic [1:0]                       status;
    logic [CNT_W-1:0]                 entry_count;
  } apq_out_t;

endpackage

// File: sv/apq_if.sv
// Request and response channel interfaces of the priority queue.
interface apq_in_if;
  import apq_pkg::*;
  logic    valid;
  logic    ready;
  apq_in_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface apq_out_if;
  import apq_pkg::*;
  logic     valid;
  logic     ready;
  apq_out_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: sv/array_priority_queue.sv
// Unsorted-table priority queue: one compare unit scans the table, then shifts.
//
// req carries one request: cmd (enqueue, dequeue, peek, clear), value_in and
// priority_in. rsp returns one result per request: top_value, top_priority,
// top_valid, status and entry_count after the request.
// Enqueue, clear and a request on an empty table need no scan: the
// result is valid the cycle after the request is taken.
// Peek walks the held entries through one comparator, one entry per cycle.
// Dequeue scans the same way, then moves every later entry down one slot
// through the table's read and write ports, one slot per cycle.
// The highest priority wins; equal priorities go to the larger value, then
// to the earlier entry.
// req.ready is low during reset and otherwise high only while the sequencer
// is idle and the result register is free or being drained. If the receiver
// stalls, the result holds in its register and no new request is taken.
// Synchronous reset empties the table and drops any pending result; the
// table contents themselves are not cleared.
`include "array_priority_queue_macros.svh"

module array_priority_queue (
  input logic        clk,
  input logic        rst,
  apq_in_if.sink     req,
  apq_out_if.source  rsp
);
  import apq_pkg::*;

  localparam logic [1:0] S_IDLE    = 2'd0;
  localparam logic [1:0] S_SCAN    = 2'd1;
  localparam logic [1:0] S_SHSTART = 2'd2;
  localparam logic [1:0] S_SHIFT   = 2'd3;

  logic [1:0]                       state;
  logic [CNT_W-1:0]                 cnt;
  logic [IDX_W-1:0]                 ptr;
  logic [1:0]                       cmd_q;
  logic signed [VALUE_WIDTH-1:0]    best_val;
  logic signed [PRIORITY_WIDTH-1:0] best_pri;
  logic [IDX_W-1:0]                 best_idx;
  logic [ENTRY_W-1:0]               rd_data;
  logic [ENTRY_W-1:0]               mem [DEPTH];
  logic                             out_valid;
  apq_out_t                         out_data;

  logic                             accept;
  logic                             enq_take;
  logic                             rsp_load;
  logic signed [VALUE_WIDTH-1:0]    rd_val;
  logic signed [PRIORITY_WIDTH-1:0] rd_pri;
  logic                             better;
  logic                             take;
  logic signed [VALUE_WIDTH-1:0]    nb_val;
  logic signed [PRIORITY_WIDTH-1:0] nb_pri;
  logic [IDX_W-1:0]                 nb_idx;
  logic                             scan_last;
  logic                             full;
  logic [IDX_W-1:0]                 rd_addr;
  logic                             wr_en;
  logic [IDX_W-1:0]                 wr_addr;
  logic [ENTRY_W-1:0]               wr_data;

  assign req.ready = !rst && (state == S_IDLE) && (!out_valid || rsp.ready);
  assign accept    = req.valid && req.ready;
  assign rsp.valid = out_valid;
  assign rsp.data  = out_data;
  assign full      = (cnt >= CNT_W'(DEPTH));
  assign enq_take  = accept && (req.data.cmd == CMD_ENQ) && !full;

  // Compare unit: current table word against the best so far.
  assign rd_val = rd_data[ENTRY_W-1 -: VALUE_WIDTH];
  assign rd_pri = rd_data[PRIORITY_WIDTH-1:0];
  assign better = (rd_pri > best_pri) || ((rd_pri == best_pri) && (rd_val > best_val));
  assign take   = (ptr == '0) || better;
  assign nb_val = take ? rd_val : best_val;
  assign nb_pri = take ? rd_pri : best_pri;
  assign nb_idx = take ? ptr : best_idx;
  assign scan_last = (CNT_W'(ptr) + CNT_W'(1)) == cnt;

  always_comb begin
    unique case (state)
      S_IDLE:    rd_addr = '0;
      S_SCAN:    rd_addr = ptr + IDX_W'(1);
      S_SHSTART: rd_addr = ptr + IDX_W'(1);
      S_SHIFT:   rd_addr = ptr + IDX_W'(2);
      default:   rd_addr = '0;
    endcase
  end

  // Load the result register when the current request finishes.
  always_comb begin
    unique case (state)
      S_IDLE: begin
        rsp_load = accept && ((req.data.cmd == CMD_ENQ) || (req.data.cmd == CMD_CLEAR) ||
                              (cnt == '0));
      end
      S_SCAN:    rsp_load = scan_last && (cmd_q != CMD_DEQ);
      S_SHSTART: rsp_load = (CNT_W'(ptr) >= cnt);
      S_SHIFT:   rsp_load = (CNT_W'(ptr) + CNT_W'(1)) == cnt;
      default:   rsp_load = 1'b0;
    endcase
  end

  assign wr_en   = enq_take || (state == S_SHIFT);
  assign wr_addr = (state == S_SHIFT) ? ptr : cnt[IDX_W-1:0];
  assign wr_data = (state == S_SHIFT) ? rd_data : {req.data.value_in, req.data.priority_in};

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

  // Sequencer and count.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (rsp_load) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            case (req.data.cmd)
              CMD_ENQ: begin
                if (!full) begin
                  cnt <= cnt + CNT_W'(1);
                end
              end
              CMD_CLEAR: cnt <= '0;
              default: begin
                if (cnt != '0) begin
                  state <= S_SCAN;
                end
              end
            endcase
          end
        end
        S_SCAN: begin
          if (scan_last) begin
            if (cmd_q == CMD_DEQ) begin
              cnt   <= cnt - CNT_W'(1);
              state <= S_SHSTART;
            end else begin
              state <= S_IDLE;
            end
          end
        end
        S_SHSTART: begin
          // Removed entry was the last one: nothing to move.
          if (CNT_W'(ptr) >= cnt) begin
            state <= S_IDLE;
          end else begin
            state <= S_SHIFT;
          end
        end
        S_SHIFT: begin
          if ((CNT_W'(ptr) + CNT_W'(1)) == cnt) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          cmd_q                 <= req.data.cmd;
          ptr                   <= '0;
          out_data.top_value    <= '0;
          out_data.top_priority <= '0;
          out_data.top_valid    <= 1'b0;
          case (req.data.cmd)
            CMD_ENQ: begin
              out_data.status      <= full ? ST_FULL : ST_OK;
              out_data.entry_count <= full ? cnt : cnt + CNT_W'(1);
            end
            CMD_DEQ: begin
              out_data.status      <= (cnt == '0) ? ST_EMPTY : ST_OK;
              out_data.entry_count <= cnt;
            end
            CMD_CLEAR: begin
              out_data.status      <= ST_OK;
              out_data.entry_count <= '0;
            end
            default: begin
              out_data.status      <= ST_OK;
              out_data.entry_count <= cnt;
            end
          endcase
        end
      end
      S_SCAN: begin
        best_val <= nb_val;
        best_pri <= nb_pri;
        best_idx <= nb_idx;
        // Hold the winner's slot for the shift.
        ptr      <= scan_last ? nb_idx : ptr + IDX_W'(1);
        if (scan_last) begin
          out_data.top_value    <= nb_val;
          out_data.top_priority <= nb_pri;
          out_data.top_valid    <= 1'b1;
          out_data.status       <= ST_OK;
          out_data.entry_count  <= (cmd_q == CMD_DEQ) ? cnt - CNT_W'(1) : cnt;
        end
      end
      S_SHIFT: ptr <= ptr + IDX_W'(1);
      default: ;
    endcase
  end

  `APQ_ASSERT_NOW(a_cnt_range, 1'b1, cnt <= CNT_W'(DEPTH))
  `APQ_ASSERT_NOW(a_busy_no_result, state == S_SCAN || state == S_SHIFT, !out_valid)
  `APQ_ASSERT_NEXT(a_enq_grows, enq_take, cnt == $past(cnt) + CNT_W'(1))
  `APQ_ASSERT_NEXT(a_clear_empties, accept && req.data.cmd == CMD_CLEAR, cnt == '0 && out_valid)
  `APQ_ASSERT_NOW(a_shift_in_range, state == S_SHIFT, CNT_W'(ptr) < cnt)

endmodule

// File: tb/tb.sv
// Self-checking testbench for the array priority queue: random and directed requests.
module tb;
  import apq_pkg::*;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int SETTLE_CYCLES  = 2 * DEPTH + 8;
  localparam int RANDOM_PER_PHASE = 220;

  localparam logic signed [31:0] INT_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] INT_MAX = 32'sh7fff_ffff;

  logic clk;
  logic rst;

  apq_in_if  req_ch ();
  apq_out_if rsp_ch ();

  array_priority_queue u_dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  // Shadow copy of the table, kept in arrival order.
  logic signed [VALUE_WIDTH-1:0]    shadow_value [DEPTH];
  logic signed [PRIORITY_WIDTH-1:0] shadow_priority [DEPTH];
  int shadow_count = 0;

  apq_in_t  requests_to_send [$];
  apq_out_t results_due [$];

  int send_idle_pct;
  int recv_stall_pct;
  int mismatches = 0;
  int quiet_cycles;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Slot of the entry served next: highest priority, then larger value, then earliest.
  function automatic int top_slot();
    int best;
    best = 0;
    for (int i = 1; i < shadow_count; i++) begin
      if (shadow_priority[i] > shadow_priority[best] ||
          (shadow_priority[i] == shadow_priority[best] &&
           shadow_value[i] > shadow_value[best]))
        best = i;
    end
    return best;
  endfunction

  // Apply one request to the shadow table and return the result it must give.
  function automatic apq_out_t serve_request(apq_in_t r);
    apq_out_t o;
    int best;
    o = '0;
    case (r.cmd) inside
      CMD_ENQ: begin
        if (shadow_count >= DEPTH) begin
          o.status = ST_FULL;
        end else begin
          shadow_value[shadow_count]    = r.value_in;
          shadow_priority[shadow_count] = r.priority_in;
          shadow_count++;
        end
      end
      CMD_DEQ, CMD_PEEK: begin
        if (shadow_count == 0) begin
          if (r.cmd == CMD_DEQ) o.status = ST_EMPTY;
        end else begin
          best = top_slot();
          o.top_value    = shadow_value[best];
          o.top_priority = shadow_priority[best];
          o.top_valid    = 1'b1;
          if (r.cmd == CMD_DEQ) begin
            // close the gap left by the removed entry
            for (int i = best; i + 1 < shadow_count; i++) begin
              shadow_value[i]    = shadow_value[i + 1];
              shadow_priority[i] = shadow_priority[i + 1];
            end
            shadow_count--;
          end
        end
      end
      default: shadow_count = 0;
    endcase
    o.entry_count = CNT_W'(shadow_count);
    return o;
  endfunction

  // Driver: hold a request until taken, then advance or idle.
  always @(posedge clk) begin
    apq_out_t due;
    if (rst) begin
      req_ch.valid <= 1'b0;
      req_ch.data  <= '0;
    end else begin
      if (req_ch.valid && req_ch.ready) begin
        due = serve_request(req_ch.data);
        results_due = {results_due, due};
      end
      if (!req_ch.valid || req_ch.ready) begin
        if (requests_to_send.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          req_ch.valid <= 1'b1;
          req_ch.data  <= requests_to_send.pop_front();
        end else begin
          req_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each result with the oldest expectation.
  always @(posedge clk) begin
    apq_out_t want;
    apq_out_t got;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      got = rsp_ch.data;
      if (results_due.size() == 0) begin
        $error("unexpected result: top_value %0d, entry_count %0d",
               got.top_value, got.entry_count);
        mismatches++;
      end else begin
        want = results_due.pop_front();
        if (got.top_value !== want.top_value) begin
          $error("top_value: expected %0d, got %0d", want.top_value, got.top_value);
          mismatches++;
        end
        if (got.top_priority !== want.top_priority) begin
          $error("top_priority: expected %0d, got %0d",
                 want.top_priority, got.top_priority);
          mismatches++;
        end
        if (got.top_valid !== want.top_valid) begin
          $error("top_valid: expected %0d, got %0d", want.top_valid, got.top_valid);
          mismatches++;
        end
        if (got.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, got.status);
          mismatches++;
        end
        if (got.entry_count !== want.entry_count) begin
          $error("entry_count: expected %0d, got %0d",
                 want.entry_count, got.entry_count);
          mismatches++;
        end
      end
    end
    rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Watchdog: end the run when nothing moves for too long.
  always @(posedge clk) begin
    if (rst || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic add_request(logic [1:0] cmd, logic signed [31:0] v, logic signed [31:0] p);
    apq_in_t r;
    r.cmd         = cmd;
    r.value_in    = v;
    r.priority_in = p;
    requests_to_send = {requests_to_send, r};
  endtask

  // Small values in 35 of 100 picks so that ties are common, extremes in 10, the rest full range.
  function automatic logic signed [31:0] pick_word();
    int sel;
    sel = $urandom_range(99);
    if (sel < 35) return $signed(32'($urandom_range(4))) - 32'sd2;
    if (sel < 45) begin
      case ($urandom_range(3))
        0: return INT_MIN;
        1: return INT_MAX;
        2: return 32'sd0;
        default: return -32'sd1;
      endcase
    end
    return $signed($urandom);
  endfunction

  task automatic add_directed();
    add_request(CMD_PEEK, 32'sd9, 32'sd9);
    add_request(CMD_DEQ, 32'sd9, 32'sd9);
    add_request(CMD_CLEAR, 32'sd0, 32'sd0);
    // lowest priority must still be served
    add_request(CMD_ENQ, INT_MIN, INT_MIN);
    add_request(CMD_PEEK, 32'sd0, 32'sd0);
    add_request(CMD_ENQ, INT_MAX, INT_MIN);
    add_request(CMD_ENQ, 32'sd5, INT_MAX);
    add_request(CMD_ENQ, -32'sd7, INT_MAX);
    add_request(CMD_ENQ, 32'sd5, INT_MAX);
    for (int i = 0; i < DEPTH - 5; i++)
      add_request(CMD_ENQ, $signed($urandom), (i % 3 == 0) ? INT_MAX : $signed($urandom));
    add_request(CMD_ENQ, 32'sd1, 32'sd1);
    add_request(CMD_PEEK, 32'sd0, 32'sd0);
    add_request(CMD_DEQ, 32'sd0, 32'sd0);
    add_request(CMD_DEQ, 32'sd0, 32'sd0);
    add_request(CMD_CLEAR, 32'sd0, 32'sd0);
    add_request(CMD_PEEK, 32'sd0, 32'sd0);
  endtask

  // Alternate filling and draining bursts so the table swings between empty and full.
  task automatic add_random(int n);
    int burst_left;
    bit filling;
    int sel;
    logic [1:0] cmd;
    burst_left = 0;
    filling = 1'b1;
    for (int k = 0; k < n; k++) begin
      if (burst_left == 0) begin
        filling = ~filling;
        burst_left = $urandom_range(40, 10);
      end
      burst_left--;
      sel = $urandom_range(99);
      if (sel == 0)
        cmd = CMD_CLEAR;
      else if (sel < 14)
        cmd = CMD_PEEK;
      else if (sel < (filling ? 80 : 28))
        cmd = CMD_ENQ;
      else
        cmd = CMD_DEQ;
      add_request(cmd, pick_word(), pick_word());
    end
  endtask

  task automatic drain_all();
    while (requests_to_send.size() > 0 || req_ch.valid || results_due.size() > 0)
      @(posedge clk);
  endtask

  initial begin
    rst <= 1'b1;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    add_directed();
    add_random(RANDOM_PER_PHASE);
    drain_all();

    // Sender idles at random here; the receiver takes every result.
    send_idle_pct = 46;
    recv_stall_pct = 0;
    add_random(RANDOM_PER_PHASE);
    drain_all();

    send_idle_pct = 0;
    recv_stall_pct = 46;
    add_random(RANDOM_PER_PHASE);
    drain_all();

    send_idle_pct = 37;
    recv_stall_pct = 37;
    add_random(RANDOM_PER_PHASE);
    drain_all();

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0 && results_due.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+sv
sv/apq_pkg.sv
sv/apq_if.sv
sv/array_priority_queue.sv
tb/tb.sv
